### hw/rtl/assert_macros.svh
// Assertion macros shared by the checker modules of this project.
// No dependencies; pulled in with `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted (active low).
`define CVD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define CVD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/cvd_pkg.sv
// Package for the congestion video-drop decider: constants, register map,
// configuration struct and the loss-percentage helper. No dependencies.
package cvd_pkg;

    localparam int TIME_BITS_DEF = 40;

    // APB register map: register i at byte address 4*i
    localparam int ADDR_W = 5;
    localparam int IDX_W  = ADDR_W - 2;
    localparam int DATA_W = 32;

    localparam logic [IDX_W-1:0] REG_UPDATE_INTERVAL = 3'd0;
    localparam logic [IDX_W-1:0] REG_DROP_LOSS_PCT   = 3'd1;
    localparam logic [IDX_W-1:0] REG_DROP_RTT_MS     = 3'd2;
    localparam logic [IDX_W-1:0] REG_KEEP_LOSS_PCT   = 3'd3;
    localparam logic [IDX_W-1:0] REG_KEEP_RTT_MS     = 3'd4;
    localparam logic [IDX_W-1:0] REG_RECOVER_DELAY   = 3'd5;

    localparam logic [15:0] RST_UPDATE_INTERVAL = 16'd1000;
    localparam logic [6:0]  RST_DROP_LOSS_PCT   = 7'd40;
    localparam logic [15:0] RST_DROP_RTT_MS     = 16'd800;
    localparam logic [6:0]  RST_KEEP_LOSS_PCT   = 7'd30;
    localparam logic [15:0] RST_KEEP_RTT_MS     = 16'd500;
    localparam logic [15:0] RST_RECOVER_DELAY   = 16'd5000;

    typedef struct packed {
        logic [15:0] update_interval_ms;
        logic [6:0]  drop_loss_pct;
        logic [15:0] drop_rtt_ms;
        logic [6:0]  keep_loss_pct;
        logic [15:0] keep_rtt_ms;
        logic [15:0] recover_delay_ms;
    } t_cfg;

    // floor(loss * 100 / 255). Estimate x/255 as (x*257) >> 16, which is
    // never high and at most one low, then fix it with one compare.
    function automatic logic [6:0] loss_pct(input logic [7:0] loss);
        logic [14:0] x;
        logic [23:0] x257;
        logic [6:0]  q0;
        logic [14:0] q255;
        logic [14:0] rem;
        x    = {1'b0, loss, 6'b0} + {2'b0, loss, 5'b0} + {5'b0, loss, 2'b0};
        x257 = {9'b0, x} + {1'b0, x, 8'b0};
        q0   = x257[22:16];
        q255 = {q0, 8'b0} - {8'b0, q0};
        rem  = x - q255;
        if (rem >= 15'd255) begin
            q0 = q0 + 7'd1;
        end
        return q0;
    endfunction

endpackage

### hw/rtl/cvd_if.sv
// Stream interfaces for the congestion video-drop decider: tick input and
// decision output, valid/ready handshake. Depends on cvd_pkg.
interface cvd_in_if #(
    parameter int TIME_BITS = cvd_pkg::TIME_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic [TIME_BITS-1:0] now_ms;
    logic                 video_live;
    logic [15:0]          video_rtt_ms;
    logic                 video_loss_valid;
    logic [7:0]           video_frac_lost;
    logic                 audio_live;
    logic [15:0]          audio_rtt_ms;
    logic                 audio_loss_valid;
    logic [7:0]           audio_frac_lost;

    modport source (
        output valid, now_ms, video_live, video_rtt_ms, video_loss_valid,
               video_frac_lost, audio_live, audio_rtt_ms, audio_loss_valid,
               audio_frac_lost,
        input  ready
    );
    modport sink (
        input  valid, now_ms, video_live, video_rtt_ms, video_loss_valid,
               video_frac_lost, audio_live, audio_rtt_ms, audio_loss_valid,
               audio_frac_lost,
        output ready
    );
endinterface

interface cvd_out_if;
    logic        valid;
    logic        ready;
    logic        drop_video;
    logic [15:0] avg_rtt_ms;
    logic [7:0]  avg_frac_lost;
    logic        updated;

    modport source (
        output valid, drop_video, avg_rtt_ms, avg_frac_lost, updated,
        input  ready
    );
    modport sink (
        input  valid, drop_video, avg_rtt_ms, avg_frac_lost, updated,
        output ready
    );
endinterface

### hw/rtl/cvd_regs.sv
// APB configuration registers of the congestion video-drop decider.
// Depends on cvd_pkg (register map, reset values, t_cfg).
module cvd_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cvd_pkg::ADDR_W-1:0]  paddr,
    input  logic [cvd_pkg::DATA_W-1:0]  pwdata,
    output logic [cvd_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output cvd_pkg::t_cfg               o_cfg
);
    cvd_pkg::t_cfg                  r_cfg;
    logic [cvd_pkg::IDX_W-1:0]      w_idx;
    logic                           w_wr;

    assign w_idx  = paddr[cvd_pkg::ADDR_W-1:2];
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.update_interval_ms <= cvd_pkg::RST_UPDATE_INTERVAL;
            r_cfg.drop_loss_pct      <= cvd_pkg::RST_DROP_LOSS_PCT;
            r_cfg.drop_rtt_ms        <= cvd_pkg::RST_DROP_RTT_MS;
            r_cfg.keep_loss_pct      <= cvd_pkg::RST_KEEP_LOSS_PCT;
            r_cfg.keep_rtt_ms        <= cvd_pkg::RST_KEEP_RTT_MS;
            r_cfg.recover_delay_ms   <= cvd_pkg::RST_RECOVER_DELAY;
        end else if (w_wr) begin
            case (w_idx)
                cvd_pkg::REG_UPDATE_INTERVAL: r_cfg.update_interval_ms <= pwdata[15:0];
                cvd_pkg::REG_DROP_LOSS_PCT:   r_cfg.drop_loss_pct      <= pwdata[6:0];
                cvd_pkg::REG_DROP_RTT_MS:     r_cfg.drop_rtt_ms        <= pwdata[15:0];
                cvd_pkg::REG_KEEP_LOSS_PCT:   r_cfg.keep_loss_pct      <= pwdata[6:0];
                cvd_pkg::REG_KEEP_RTT_MS:     r_cfg.keep_rtt_ms        <= pwdata[15:0];
                cvd_pkg::REG_RECOVER_DELAY:   r_cfg.recover_delay_ms   <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            cvd_pkg::REG_UPDATE_INTERVAL: prdata = {16'b0, r_cfg.update_interval_ms};
            cvd_pkg::REG_DROP_LOSS_PCT:   prdata = {25'b0, r_cfg.drop_loss_pct};
            cvd_pkg::REG_DROP_RTT_MS:     prdata = {16'b0, r_cfg.drop_rtt_ms};
            cvd_pkg::REG_KEEP_LOSS_PCT:   prdata = {25'b0, r_cfg.keep_loss_pct};
            cvd_pkg::REG_KEEP_RTT_MS:     prdata = {16'b0, r_cfg.keep_rtt_ms};
            cvd_pkg::REG_RECOVER_DELAY:   prdata = {16'b0, r_cfg.recover_delay_ms};
            default:                      prdata = '0;
        endcase
    end
endmodule

### hw/rtl/congestion_video_drop_decider.sv
// Congestion video-drop decider. Each input beat is a millisecond tick with
// the video and audio sessions' liveness, RTT and fractional loss; each tick
// yields exactly one output beat. At most once per update interval the block
// halves the chosen figures (video first, audio as fallback) into running
// averages and decides whether video should be dropped: dropping starts when
// loss percent or averaged RTT exceeds the drop thresholds, and ends only
// after both stay at or below the keep thresholds for longer than the
// recovery delay. Rate: one tick per clock while the result side does not
// stall. Each beat passes through the input register, then the result
// register. The whole update (TIME_BITS-bit time compares, averaging,
// constant-divisor loss percentage) is one combinational step between those
// two registers, so the updated state is ready for the very next tick.
// Thresholds are written over APB at byte address 4*i; write only while idle.
// Depends on cvd_pkg, cvd_if (cvd_in_if, cvd_out_if) and cvd_regs.
module congestion_video_drop_decider #(
    parameter int TIME_BITS = cvd_pkg::TIME_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    cvd_in_if.sink                      i_item,
    cvd_out_if.source                   o_result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [cvd_pkg::ADDR_W-1:0]  paddr,
    input  logic [cvd_pkg::DATA_W-1:0]  pwdata,
    output logic [cvd_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    cvd_pkg::t_cfg w_cfg;

    cvd_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // ---------------- input register ----------------
    logic                 r_s1_valid;
    logic [TIME_BITS-1:0] r_now;
    logic                 r_v_live;
    logic [15:0]          r_v_rtt;
    logic                 r_v_lv;
    logic [7:0]           r_v_loss;
    logic                 r_a_live;
    logic [15:0]          r_a_rtt;
    logic                 r_a_lv;
    logic [7:0]           r_a_loss;

    // ---------------- decision state ----------------
    logic [TIME_BITS-1:0] r_last_upd, n_last_upd;   // zero = never updated
    logic [15:0]          r_rtt_avg,  n_rtt_avg;
    logic [7:0]           r_loss_avg, n_loss_avg;
    logic                 r_dropping, n_dropping;
    logic [TIME_BITS-1:0] r_rec_start, n_rec_start; // zero = no recovery running

    // ---------------- result register ----------------
    logic                 r_out_valid;
    logic                 r_out_drop;
    logic [15:0]          r_out_rtt;
    logic [7:0]           r_out_loss;
    logic                 r_out_upd;

    // Stage 1 retires its beat whenever the result register is free or
    // draining this cycle; the input side sees ready while stage 1 is
    // empty or retiring, so a stalled result holds off new ticks only once
    // stage 1 is full as well.
    logic w_s1_go;
    assign w_s1_go      = r_s1_valid && (!r_out_valid || o_result.ready);
    assign i_item.ready = !r_s1_valid || w_s1_go;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_item.valid && i_item.ready) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_now    <= i_item.now_ms;
            r_v_live <= i_item.video_live;
            r_v_rtt  <= i_item.video_rtt_ms;
            r_v_lv   <= i_item.video_loss_valid;
            r_v_loss <= i_item.video_frac_lost;
            r_a_live <= i_item.audio_live;
            r_a_rtt  <= i_item.audio_rtt_ms;
            r_a_lv   <= i_item.audio_loss_valid;
            r_a_loss <= i_item.audio_frac_lost;
        end
    end

    // ---------------- update logic ----------------
    logic [TIME_BITS-1:0] w_since_upd;
    logic [TIME_BITS-1:0] w_since_rec;
    logic                 w_due;
    logic                 w_have_rtt;
    logic [15:0]          w_rtt;
    logic                 w_v_loss_ok;
    logic                 w_have_loss;
    logic [7:0]           w_loss;
    logic [16:0]          w_rtt_sum;
    logic [8:0]           w_loss_sum;
    logic [6:0]           w_pct;
    logic                 w_bad;
    logic                 w_worse;

    // Time differences wrap modulo 2^TIME_BITS.
    assign w_since_upd = r_now - r_last_upd;
    assign w_since_rec = r_now - r_rec_start;
    assign w_due       = (r_last_upd == '0) ||
                         (w_since_upd > TIME_BITS'(w_cfg.update_interval_ms));

    // Video figures first; audio fills in whichever one is missing.
    assign w_have_rtt  = r_v_live || r_a_live;
    assign w_rtt       = r_v_live ? r_v_rtt : r_a_rtt;
    assign w_v_loss_ok = r_v_live && r_v_lv;
    assign w_have_loss = w_v_loss_ok || (r_a_live && r_a_lv);
    assign w_loss      = w_v_loss_ok ? r_v_loss : r_a_loss;

    assign w_rtt_sum  = {1'b0, r_rtt_avg} + {1'b0, w_rtt};
    assign w_loss_sum = {1'b0, r_loss_avg} + {1'b0, w_loss};

    always_comb begin
        n_last_upd  = r_last_upd;
        n_rtt_avg   = r_rtt_avg;
        n_loss_avg  = r_loss_avg;
        n_dropping  = r_dropping;
        n_rec_start = r_rec_start;
        if (w_due) begin
            n_last_upd = r_now;
            if (w_have_rtt) begin
                n_rtt_avg = w_rtt_sum[16:1];
            end
            if (w_have_loss) begin
                n_loss_avg = w_loss_sum[8:1];
            end
        end
        // Thresholds use the freshly averaged figures.
        w_pct   = cvd_pkg::loss_pct(n_loss_avg);
        w_bad   = (w_pct > w_cfg.keep_loss_pct) || (n_rtt_avg > w_cfg.keep_rtt_ms);
        w_worse = (w_pct > w_cfg.drop_loss_pct) || (n_rtt_avg > w_cfg.drop_rtt_ms);
        if (w_due) begin
            if (r_dropping) begin
                if (w_bad) begin
                    n_rec_start = '0;
                end else if (r_rec_start == '0) begin
                    n_rec_start = r_now;
                end else if (w_since_rec > TIME_BITS'(w_cfg.recover_delay_ms)) begin
                    // start stays until the next non-dropping update
                    n_dropping = 1'b0;
                end
            end else begin
                n_dropping  = w_worse;
                n_rec_start = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_upd  <= '0;
            r_rtt_avg   <= '0;
            r_loss_avg  <= '0;
            r_dropping  <= 1'b0;
            r_rec_start <= '0;
        end else if (w_s1_go) begin
            r_last_upd  <= n_last_upd;
            r_rtt_avg   <= n_rtt_avg;
            r_loss_avg  <= n_loss_avg;
            r_dropping  <= n_dropping;
            r_rec_start <= n_rec_start;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_go) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_go) begin
            r_out_drop <= n_dropping;
            r_out_rtt  <= n_rtt_avg;
            r_out_loss <= n_loss_avg;
            r_out_upd  <= w_due;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.drop_video    = r_out_drop;
    assign o_result.avg_rtt_ms    = r_out_rtt;
    assign o_result.avg_frac_lost = r_out_loss;
    assign o_result.updated       = r_out_upd;
endmodule

### hw/rtl/cvd_chk.sv
// Port-level checker for the congestion video-drop decider, bound to the top.
// Depends on assert_macros.svh and the top level's ports.
`include "assert_macros.svh"

module cvd_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_drop_video,
    input logic [15:0] i_avg_rtt_ms,
    input logic [7:0]  i_avg_frac_lost,
    input logic        i_updated,
    input logic        i_pready
);
    // Last delivered result beat.
    logic        r_seen;
    logic        r_drop;
    logic [15:0] r_rtt;
    logic [7:0]  r_loss;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
        end else if (i_out_valid && i_out_ready) begin
            r_seen <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_out_valid && i_out_ready) begin
            r_drop <= i_drop_video;
            r_rtt  <= i_avg_rtt_ms;
            r_loss <= i_avg_frac_lost;
        end
    end

    // A stalled result holds.
    `CVD_ASSERT(a_out_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_drop_video) && $stable(i_avg_rtt_ms) && $stable(i_avg_frac_lost) && $stable(i_updated)), "result changed while stalled")

    // Without an interval update the decision state must not move.
    `CVD_ASSERT(a_no_upd_same, i_clk, i_rst_n, (i_out_valid && i_out_ready && !i_updated && r_seen |-> i_drop_video == r_drop && i_avg_rtt_ms == r_rtt && i_avg_frac_lost == r_loss), "state moved on a tick without update")

    // Reset empties the result register.
    `CVD_ASSERT_ALWAYS(a_rst_empty, i_clk, (!i_rst_n |=> !i_out_valid), "result valid right after reset")

    // Register port never waits.
    `CVD_ASSERT(a_pready, i_clk, i_rst_n, (i_pready), "pready low")
endmodule

bind congestion_video_drop_decider cvd_chk u_cvd_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_result.valid),
    .i_out_ready     (o_result.ready),
    .i_drop_video    (o_result.drop_video),
    .i_avg_rtt_ms    (o_result.avg_rtt_ms),
    .i_avg_frac_lost (o_result.avg_frac_lost),
    .i_updated       (o_result.updated),
    .i_pready        (pready)
);

### dv/tb_congestion_video_drop_decider.sv
`timescale 1ns / 100ps
// Self-checking bench for congestion_video_drop_decider: a directed tick table, then
// random tick streams under several threshold settings, scored against a local model.
// Depends on cvd_pkg, cvd_if (cvd_in_if, cvd_out_if) and the decider RTL.
module tb_congestion_video_drop_decider;

    localparam int TB              = cvd_pkg::TIME_BITS_DEF;
    localparam int NDIR            = 23;
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 120;
    localparam logic [TB-1:0] TMAX = '1;

    // one input beat: a millisecond tick with both sessions' figures
    typedef struct packed {
        logic [TB-1:0] now_ms;
        logic          video_live;
        logic [15:0]   video_rtt_ms;
        logic          video_loss_valid;
        logic [7:0]    video_frac_lost;
        logic          audio_live;
        logic [15:0]   audio_rtt_ms;
        logic          audio_loss_valid;
        logic [7:0]    audio_frac_lost;
    } t_tick;

    // one output beat
    typedef struct packed {
        logic        drop_video;
        logic [15:0] avg_rtt_ms;
        logic [7:0]  avg_frac_lost;
        logic        updated;
    } t_verdict;

    // directed row: typed = 1 means the verdict below is checked as written
    typedef struct packed {
        t_tick    t;
        logic     typed;
        t_verdict v;
    } t_dir_row;

    localparam t_verdict NO_VERDICT = '0;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                         psel;
    logic                         penable;
    logic                         pwrite;
    logic [cvd_pkg::ADDR_W-1:0]   paddr;
    logic [cvd_pkg::DATA_W-1:0]   pwdata;
    logic [cvd_pkg::DATA_W-1:0]   prdata;
    logic                         pready;

    cvd_in_if #(.TIME_BITS(TB)) tick_if ();
    cvd_out_if                  verdict_if ();

    congestion_video_drop_decider #(.TIME_BITS(TB)) uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (tick_if),
        .o_result (verdict_if),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Local decider model: shadow thresholds plus a copy of the state.
    // ------------------------------------------------------------------
    cvd_pkg::t_cfg thr;
    logic [TB-1:0] last_upd_ms;
    logic [TB-1:0] recovery_ms;    // zero = no recovery window open
    logic [15:0]   rtt_avg;
    logic [7:0]    loss_avg;
    logic          dropping;

    t_verdict      pending_verdicts[$];
    int            errors;

    // stimulus side state
    logic [TB-1:0] run_now;        // running clock of well-formed streams
    bit            net_bad;        // current network profile of the stream
    bit            in_burst;       // back-to-back ticks, no source gaps
    bit            out_burst;      // sink never stalls

    function automatic t_verdict decide_tick(input t_tick t);
        logic          have_rtt;
        logic          have_loss;
        logic [15:0]   rtt;
        logic [7:0]    loss;
        logic [16:0]   rtt_sum;
        logic [8:0]    loss_sum;
        logic [TB-1:0] dt;
        int unsigned   pct;
        logic          bad;
        t_verdict      v;
        v.updated = 1'b0;
        dt = t.now_ms - last_upd_ms;
        if (last_upd_ms == '0 || dt > thr.update_interval_ms) begin
            v.updated   = 1'b1;
            last_upd_ms = t.now_ms;
            have_rtt    = 1'b0;
            have_loss   = 1'b0;
            rtt         = '0;
            loss        = '0;
            // video figures first, audio fills whichever is missing
            if (t.video_live) begin
                have_rtt = 1'b1;
                rtt      = t.video_rtt_ms;
                if (t.video_loss_valid) begin
                    have_loss = 1'b1;
                    loss      = t.video_frac_lost;
                end
            end
            if (t.audio_live) begin
                if (!have_rtt) begin
                    have_rtt = 1'b1;
                    rtt      = t.audio_rtt_ms;
                end
                if (!have_loss && t.audio_loss_valid) begin
                    have_loss = 1'b1;
                    loss      = t.audio_frac_lost;
                end
            end
            if (have_rtt) begin
                rtt_sum = {1'b0, rtt_avg} + {1'b0, rtt};
                rtt_avg = rtt_sum[16:1];
            end
            if (have_loss) begin
                loss_sum = {1'b0, loss_avg} + {1'b0, loss};
                loss_avg = loss_sum[8:1];
            end
            pct = int'(loss_avg) * 100 / 255;
            if (dropping) begin
                bad = (pct > thr.keep_loss_pct) || (rtt_avg > thr.keep_rtt_ms);
                if (bad) begin
                    recovery_ms = '0;
                end else if (recovery_ms == '0) begin
                    recovery_ms = t.now_ms;
                end else if (TB'(t.now_ms - recovery_ms) > thr.recover_delay_ms) begin
                    // start time is kept; the next calm update clears it
                    dropping = 1'b0;
                end
            end else begin
                dropping    = (pct > thr.drop_loss_pct) || (rtt_avg > thr.drop_rtt_ms);
                recovery_ms = '0;
            end
        end
        v.drop_video    = dropping;
        v.avg_rtt_ms    = rtt_avg;
        v.avg_frac_lost = loss_avg;
        return v;
    endfunction

    // per-item idle draw, with occasional switches into gap-free stretches
    function automatic int unsigned idle_cycles(inout bit burst);
        if ($urandom_range(0, 39) == 0) begin
            burst = !burst;
        end
        return burst ? 0 : $urandom_range(0, 19);
    endfunction

    function automatic t_dir_row dr(input logic [TB-1:0] now,
                                    input int vl, input logic [15:0] vr,
                                    input int vlv, input logic [7:0] vf,
                                    input int al, input logic [15:0] ar,
                                    input int alv, input logic [7:0] af,
                                    input int typed, input t_verdict v);
        t_dir_row r;
        r.t     = {now, vl[0], vr, vlv[0], vf, al[0], ar, alv[0], af};
        r.typed = typed[0];
        r.v     = v;
        return r;
    endfunction

    // Random tick. Most beats follow a running clock that steps around the
    // update interval, with figures from a good or bad network profile so the
    // drop flag sets and recovers; the rest is noise: arbitrary fields, time
    // zero, jumps and times just short of the wrap point.
    function automatic t_tick gen_tick();
        t_tick       t;
        int unsigned intv;
        int unsigned lcap;
        logic [TB-1:0] stride;
        intv = thr.update_interval_ms;
        if ($urandom_range(0, 14) == 0) begin
            net_bad = !net_bad;
        end
        if ($urandom_range(0, 99) < 82) begin
            case ($urandom_range(0, 3))
                0: begin
                    stride = TB'($urandom_range(0, intv));
                end
                1, 2: begin
                    stride = TB'(intv + $urandom_range(1, 3));
                end
                default: begin
                    stride = TB'(intv + 1 + $urandom_range(0, intv + 50));
                end
            endcase
            run_now            = run_now + stride;
            t.now_ms           = run_now;
            t.video_live       = ($urandom_range(0, 9) != 0);
            t.video_loss_valid = ($urandom_range(0, 5) != 0);
            t.audio_live       = 1'($urandom_range(0, 1));
            t.audio_loss_valid = 1'($urandom_range(0, 1));
            if (net_bad) begin
                t.video_rtt_ms    = 16'($urandom_range(thr.drop_rtt_ms, 16'hFFFF));
                t.audio_rtt_ms    = 16'($urandom_range(thr.drop_rtt_ms, 16'hFFFF));
                t.video_frac_lost = 8'($urandom_range(100, 255));
                t.audio_frac_lost = 8'($urandom_range(100, 255));
            end else begin
                lcap = thr.keep_loss_pct * 255 / 100;
                if (lcap > 255) begin
                    lcap = 255;
                end
                t.video_rtt_ms    = 16'($urandom_range(0, thr.keep_rtt_ms));
                t.audio_rtt_ms    = 16'($urandom_range(0, thr.keep_rtt_ms));
                t.video_frac_lost = 8'($urandom_range(0, lcap));
                t.audio_frac_lost = 8'($urandom_range(0, lcap));
            end
        end else begin
            t = t_tick'({$urandom, $urandom, $urandom});
            case ($urandom_range(0, 3))
                0: t.now_ms = '0;
                1: t.now_ms = TMAX - TB'($urandom_range(0, 3000));
                default: t.now_ms = TB'({$urandom, $urandom});
            endcase
            run_now = t.now_ms;
        end
        return t;
    endfunction

    // ------------------------------------------------------------------
    // Drivers. Everything changes at the falling edge; beats are taken at
    // the rising edge. Tasks enter and leave on a falling edge.
    // ------------------------------------------------------------------
    task automatic push_tick(input t_tick t, input logic typed, input t_verdict tv);
        int unsigned gap;
        t_verdict    v;
        gap = idle_cycles(in_burst);
        if (gap != 0) begin
            tick_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        tick_if.valid            = 1'b1;
        tick_if.now_ms           = t.now_ms;
        tick_if.video_live       = t.video_live;
        tick_if.video_rtt_ms     = t.video_rtt_ms;
        tick_if.video_loss_valid = t.video_loss_valid;
        tick_if.video_frac_lost  = t.video_frac_lost;
        tick_if.audio_live       = t.audio_live;
        tick_if.audio_rtt_ms     = t.audio_rtt_ms;
        tick_if.audio_loss_valid = t.audio_loss_valid;
        tick_if.audio_frac_lost  = t.audio_frac_lost;
        do @(posedge i_clk); while (tick_if.ready !== 1'b1);
        // beat taken: model steps even for typed rows to keep its state
        v = decide_tick(t);
        pending_verdicts.insert(pending_verdicts.size(), typed ? tv : v);
        @(negedge i_clk);
    endtask

    // APB write, then read back the same register
    task automatic reg_write(input logic [cvd_pkg::IDX_W-1:0] idx,
                             input logic [cvd_pkg::DATA_W-1:0] val);
        logic [cvd_pkg::DATA_W-1:0] rd_exp;
        case (idx)
            cvd_pkg::REG_UPDATE_INTERVAL: thr.update_interval_ms = val[15:0];
            cvd_pkg::REG_DROP_LOSS_PCT:   thr.drop_loss_pct      = val[6:0];
            cvd_pkg::REG_DROP_RTT_MS:     thr.drop_rtt_ms        = val[15:0];
            cvd_pkg::REG_KEEP_LOSS_PCT:   thr.keep_loss_pct      = val[6:0];
            cvd_pkg::REG_KEEP_RTT_MS:     thr.keep_rtt_ms        = val[15:0];
            default:                      thr.recover_delay_ms   = val[15:0];
        endcase
        rd_exp  = (idx == cvd_pkg::REG_DROP_LOSS_PCT || idx == cvd_pkg::REG_KEEP_LOSS_PCT) ?
                  {25'b0, val[6:0]} : {16'b0, val[15:0]};
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        @(negedge i_clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (prdata !== rd_exp) begin
            $display("%0t: reg %0d readback expected %0h, got %0h", $time, idx, rd_exp, prdata);
            errors++;
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic program_thresholds(input cvd_pkg::t_cfg c);
        reg_write(cvd_pkg::REG_UPDATE_INTERVAL, {16'b0, c.update_interval_ms});
        reg_write(cvd_pkg::REG_DROP_LOSS_PCT,   {25'b0, c.drop_loss_pct});
        reg_write(cvd_pkg::REG_DROP_RTT_MS,     {16'b0, c.drop_rtt_ms});
        reg_write(cvd_pkg::REG_KEEP_LOSS_PCT,   {25'b0, c.keep_loss_pct});
        reg_write(cvd_pkg::REG_KEEP_RTT_MS,     {16'b0, c.keep_rtt_ms});
        reg_write(cvd_pkg::REG_RECOVER_DELAY,   {16'b0, c.recover_delay_ms});
    endtask

    // registers only change with nothing in flight; every tick yields a beat
    task automatic drain();
        tick_if.valid = 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    function automatic cvd_pkg::t_cfg phase_thresholds(input int p);
        cvd_pkg::t_cfg c;
        case (p)
            1: c = '0;                                   // everything at zero
            2: c = '1;                                   // everything at max, pct 127
            3: c = {16'd10, 7'd100, 16'd1000, 7'd50, 16'd300, 16'd50};
            4: c = {16'd0, 7'd40, 16'd800, 7'd30, 16'd500, 16'd0};
            5: c = cvd_pkg::t_cfg'({$urandom, $urandom, $urandom});
            6: begin
                c.update_interval_ms = 16'($urandom_range(0, 300));
                c.drop_loss_pct      = 7'($urandom_range(20, 60));
                c.drop_rtt_ms        = 16'($urandom_range(300, 3000));
                c.keep_loss_pct      = 7'($urandom_range(0, c.drop_loss_pct));
                c.keep_rtt_ms        = 16'($urandom_range(0, c.drop_rtt_ms));
                c.recover_delay_ms   = 16'($urandom_range(0, 2000));
            end
            default: c = {cvd_pkg::RST_UPDATE_INTERVAL, cvd_pkg::RST_DROP_LOSS_PCT,
                          cvd_pkg::RST_DROP_RTT_MS, cvd_pkg::RST_KEEP_LOSS_PCT,
                          cvd_pkg::RST_KEEP_RTT_MS, cvd_pkg::RST_RECOVER_DELAY};
        endcase
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Sink side: random stalls per beat, and the scoreboard.
    // ------------------------------------------------------------------
    initial begin
        int unsigned stall;
        verdict_if.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            stall = idle_cycles(out_burst);
            if (stall != 0) begin
                verdict_if.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            verdict_if.ready = 1'b1;
            do @(posedge i_clk); while (verdict_if.valid !== 1'b1);
            @(negedge i_clk);
        end
    end

    function automatic void check_field(input string name, input logic [15:0] exp_v,
                                        input logic [15:0] got_v);
        if (got_v !== exp_v) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, got_v);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_verdict exp_v;
        if (i_rst_n && verdict_if.valid === 1'b1 && verdict_if.ready === 1'b1) begin
            if (pending_verdicts.size() == 0) begin
                $display("%0t: unexpected beat, expected none, got drop %0b rtt %0d loss %0d",
                         $time, verdict_if.drop_video, verdict_if.avg_rtt_ms,
                         verdict_if.avg_frac_lost);
                errors++;
            end else begin
                exp_v = pending_verdicts.pop_front();
                check_field("drop_video",    16'(exp_v.drop_video),
                            16'(verdict_if.drop_video));
                check_field("avg_rtt_ms",    exp_v.avg_rtt_ms, verdict_if.avg_rtt_ms);
                check_field("avg_frac_lost", 16'(exp_v.avg_frac_lost),
                            16'(verdict_if.avg_frac_lost));
                check_field("updated",       16'(exp_v.updated),
                            16'(verdict_if.updated));
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        t_dir_row dir_tab [NDIR];

        tick_if.valid = 1'b0;
        tick_if.now_ms = '0;
        tick_if.video_live = 1'b0;
        tick_if.video_rtt_ms = '0;
        tick_if.video_loss_valid = 1'b0;
        tick_if.video_frac_lost = '0;
        tick_if.audio_live = 1'b0;
        tick_if.audio_rtt_ms = '0;
        tick_if.audio_loss_valid = 1'b0;
        tick_if.audio_frac_lost = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        errors    = 0;
        in_burst  = 1'b0;
        out_burst = 1'b0;
        net_bad   = 1'b0;

        thr         = phase_thresholds(0);
        last_upd_ms = '0;
        recovery_ms = '0;
        rtt_avg     = '0;
        loss_avg    = '0;
        dropping    = 1'b0;

        // Directed ticks under reset thresholds. Interval is strict (1000 ms
        // apart is not due), audio fills in missing video figures, a tick at
        // time zero forces the next one due, and time wraps at 2^TB.
        dir_tab = '{
            // first tick after reset always updates; nothing live
            dr(40'd5,    0, 16'd0,     0, 8'd0,   0, 16'd0,     0, 8'd0,
               1, {1'b0, 16'd0, 8'd0, 1'b1}),
            dr(40'd6,    1, 16'hFFFF,  1, 8'hFF,  0, 16'd0,     0, 8'd0,
               1, {1'b0, 16'd0, 8'd0, 1'b0}),
            // exactly one interval later: not yet due
            dr(40'd1005, 1, 16'hFFFF,  1, 8'hFF,  0, 16'd0,     0, 8'd0,
               1, {1'b0, 16'd0, 8'd0, 1'b0}),
            // full-scale video figures: 49 % and 32767 ms, both over
            dr(40'd1006, 1, 16'hFFFF,  1, 8'hFF,  1, 16'd0,     1, 8'd0,
               1, {1'b1, 16'd32767, 8'd127, 1'b1}),
            // audio only
            dr(40'd2008, 0, 16'hFFFF,  1, 8'hFF,  1, 16'd0,     1, 8'd0,   0, NO_VERDICT),
            // video rtt, audio loss
            dr(40'd3009, 1, 16'd0,     0, 8'hFF,  1, 16'hFFFF,  1, 8'd0,   0, NO_VERDICT),
            // averages decay toward the keep thresholds
            dr(40'd4010, 1, 16'd0,     1, 8'd0,   0, 16'd0,     0, 8'd0,   0, NO_VERDICT),
            dr(40'd5011, 1, 16'd0,     1, 8'd0,   0, 16'd0,     0, 8'd0,   0, NO_VERDICT),
            dr(40'd6012, 1, 16'd0,     1, 8'd0,   0, 16'd0,     0, 8'd0,   0, NO_VERDICT),
            dr(40'd7013, 1, 16'd0,     1, 8'd0,   0, 16'd0,     0, 8'd0,   0, NO_VERDICT),
            // calm: recovery window opens
            dr(40'd8014, 1, 16'd0,     1, 8'd0,   0, 16'd0,     0, 8'd0,   0, NO_VERDICT),
            // recovery delay passed by 1 ms: drop clears
            dr(40'd13015, 1, 16'd0,    1, 8'd0,   0, 16'd0,     0, 8'd0,   0, NO_VERDICT),
            dr(40'd13016, 0, 16'hFFFF, 1, 8'hFF,  0, 16'hFFFF,  1, 8'hFF,  0, NO_VERDICT),
            // time zero, then the very next tick is due again
            dr(40'd0,    0, 16'd0,     0, 8'd0,   0, 16'd0,     0, 8'd0,   0, NO_VERDICT),
            dr(40'd1,    1, 16'd2000,  1, 8'd128, 0, 16'd0,     0, 8'd0,   0, NO_VERDICT),
            // near the wrap point; video loss invalid and no audio: loss held
            dr(TMAX - 40'd9, 1, 16'd0, 0, 8'hFF,  0, 16'hFFFF,  1, 8'hFF,  0, NO_VERDICT),
            dr(TMAX - 40'd4, 1, 16'd0, 1, 8'd0,   1, 16'd0,     1, 8'd0,   0, NO_VERDICT),
            // across the wrap: 1000 ms apart, then 1001
            dr(40'd990,  1, 16'd0,     1, 8'd0,   1, 16'd0,     1, 8'd0,   0, NO_VERDICT),
            dr(40'd991,  0, 16'hFFFF,  1, 8'hFF,  1, 16'd0,     0, 8'hFF,  0, NO_VERDICT),
            // nothing live: both averages held
            dr(40'd2000, 0, 16'd0,     0, 8'd0,   0, 16'd0,     0, 8'd0,   0, NO_VERDICT),
            // figures without liveness are ignored
            dr(40'd3010, 0, 16'hFFFF,  1, 8'hFF,  0, 16'hFFFF,  1, 8'hFF,  0, NO_VERDICT),
            dr(40'd9000, 1, 16'd0,     1, 8'd0,   1, 16'd0,     1, 8'd0,   0, NO_VERDICT),
            // every field at its top value
            dr(TMAX,     1, 16'hFFFF,  1, 8'hFF,  1, 16'hFFFF,  1, 8'hFF,  0, NO_VERDICT)
        };

        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < NDIR; i++) begin
            push_tick(dir_tab[i].t, dir_tab[i].typed, dir_tab[i].v);
        end

        // random streams; phase 0 keeps the reset thresholds
        run_now = 40'd50000;
        for (int p = 0; p < PHASES; p++) begin
            if (p != 0) begin
                drain();
                program_thresholds(phase_thresholds(p));
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                push_tick(gen_tick(), 1'b0, NO_VERDICT);
            end
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
